[src/drae_pkg.sv]
// ----------------------------------------------------------------------------
// drae_pkg
// Shared types and constants for the DNS reply A-record extractor.
// ----------------------------------------------------------------------------
package drae_pkg;

    localparam int MAX_MSG_BYTES_DEF = 1024;
    localparam int FIFO_DEPTH        = 8;

    localparam logic [3:0]  HDR_BYTES      = 4'd12;
    localparam logic [3:0]  OFS_RCODE      = 4'd3;
    localparam logic [3:0]  OFS_ANCOUNT_HI = 4'd6;
    localparam logic [3:0]  OFS_ANCOUNT_LO = 4'd7;
    localparam logic [3:0]  OFS_HDR_END    = 4'd11;
    localparam logic [3:0]  RCODE_NXDOMAIN = 4'd3;
    localparam logic [5:0]  LABEL_MAX      = 6'd63;
    localparam logic [3:0]  QFIX_BYTES     = 4'd4;
    localparam logic [3:0]  AFIX_BYTES     = 4'd10;
    localparam logic [3:0]  IPV4_BYTES     = 4'd4;
    localparam logic [3:0]  FIDX_MAX       = 4'd15;
    localparam logic [15:0] WANTED_DEF     = 16'd1;

    localparam logic KIND_ADDR   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        PH_HDR  = 4'd0,
        PH_QLEN = 4'd1,
        PH_QLAB = 4'd2,
        PH_QPTR = 4'd3,
        PH_QFIX = 4'd4,
        PH_QBAD = 4'd5,
        PH_ALEN = 4'd6,
        PH_ALAB = 4'd7,
        PH_APTR = 4'd8,
        PH_AFIX = 4'd9,
        PH_ADAT = 4'd10,
        PH_IDLE = 4'd11
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NXDOMAIN  = 3'd2,
        ST_DNS_ERROR = 3'd3,
        ST_NO_RECS   = 3'd4,
        ST_BAD_QUEST = 3'd5,
        ST_NO_A      = 3'd6
    } t_status;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [2:0]  status;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    vld_a;
        logic    vld_b;
        t_result a;
        t_result b;
    } t_push;

endpackage

[src/drae_parser.sv]
// ----------------------------------------------------------------------------
// drae_parser
// Input register and per-byte DNS reply parser; emits up to two results.
// ----------------------------------------------------------------------------
module drae_parser
    import drae_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output t_push       o_push
);

    localparam int OFS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [OFS_W-1:0] OFS_MAX = OFS_W'(MAX_MESSAGE_BYTES);

    logic             r_in_vld;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic [15:0]      r_wanted;

    logic [OFS_W-1:0] r_offset, n_offset;
    t_phase           r_phase, n_phase;
    logic [15:0]      r_ancount, n_ancount;
    logic [3:0]       r_rcode, n_rcode;
    logic [15:0]      r_left, n_left;
    logic [3:0]       r_fidx, n_fidx;
    logic [5:0]       r_lbl, n_lbl;
    logic [15:0]      r_rtype, n_rtype;
    logic [15:0]      r_rdlen, n_rdlen;
    logic [31:0]      r_addr, n_addr;
    logic             r_found, n_found;

    logic             hit;
    logic             rec_done;
    t_status          status;
    logic [7:0]       b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_wanted <= WANTED_DEF;
        end else begin
            r_in_vld <= i_vld;
            if (i_cfg_we) begin
                r_wanted <= i_cfg_wdata;
            end
        end
        r_in_byte <= i_byte;
        r_in_last <= i_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_phase   <= PH_HDR;
            r_ancount <= '0;
            r_rcode   <= '0;
            r_left    <= '0;
            r_fidx    <= '0;
            r_lbl     <= '0;
            r_rtype   <= '0;
            r_rdlen   <= '0;
            r_addr    <= '0;
            r_found   <= 1'b0;
        end else if (r_in_vld) begin
            r_offset  <= n_offset;
            r_phase   <= n_phase;
            r_ancount <= n_ancount;
            r_rcode   <= n_rcode;
            r_left    <= n_left;
            r_fidx    <= n_fidx;
            r_lbl     <= n_lbl;
            r_rtype   <= n_rtype;
            r_rdlen   <= n_rdlen;
            r_addr    <= n_addr;
            r_found   <= n_found;
        end
    end

    always_comb begin
        b         = r_in_byte;
        n_offset  = r_offset;
        n_phase   = r_phase;
        n_ancount = r_ancount;
        n_rcode   = r_rcode;
        n_left    = r_left;
        n_fidx    = r_fidx;
        n_lbl     = r_lbl;
        n_rtype   = r_rtype;
        n_rdlen   = r_rdlen;
        n_addr    = r_addr;
        n_found   = r_found;
        hit       = 1'b0;
        rec_done  = 1'b0;
        status    = ST_OK;

        if (r_offset < OFS_MAX) begin
            n_offset = r_offset + OFS_W'(1);
            case (r_phase)
                PH_HDR: begin
                    if (r_offset == OFS_W'(OFS_RCODE)) begin
                        n_rcode = b[3:0];
                    end
                    if (r_offset == OFS_W'(OFS_ANCOUNT_HI)) begin
                        n_ancount = {b, 8'h00};
                    end
                    if (r_offset == OFS_W'(OFS_ANCOUNT_LO)) begin
                        n_ancount = {r_ancount[15:8], b};
                    end
                    if (r_offset == OFS_W'(OFS_HDR_END)) begin
                        if (r_rcode != 4'd0 || r_ancount == 16'd0) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_left  = r_ancount;
                            n_phase = PH_QLEN;
                        end
                    end
                end
                PH_QLEN, PH_ALEN: begin
                    n_fidx = '0;
                    if (b == 8'd0) begin
                        n_phase = (r_phase == PH_QLEN) ? PH_QFIX : PH_AFIX;
                    end else if (b[7:6] == 2'b11) begin
                        n_phase = (r_phase == PH_QLEN) ? PH_QPTR : PH_APTR;
                    end else if (b > {2'b00, LABEL_MAX}) begin
                        n_phase = (r_phase == PH_QLEN) ? PH_QBAD : PH_IDLE;
                    end else begin
                        n_lbl   = b[5:0];
                        n_phase = (r_phase == PH_QLEN) ? PH_QLAB : PH_ALAB;
                    end
                end
                PH_QLAB, PH_ALAB: begin
                    n_lbl = r_lbl - 6'd1;
                    if (n_lbl == 6'd0) begin
                        n_phase = (r_phase == PH_QLAB) ? PH_QLEN : PH_ALEN;
                    end
                end
                PH_QPTR, PH_APTR: begin
                    n_phase = (r_phase == PH_QPTR) ? PH_QFIX : PH_AFIX;
                    n_fidx  = '0;
                end
                PH_QFIX: begin
                    n_fidx = r_fidx + 4'd1;
                    if (n_fidx >= QFIX_BYTES) begin
                        n_phase = PH_ALEN;
                    end
                end
                PH_AFIX: begin
                    if (r_fidx == 4'd0) begin
                        n_rtype = {b, 8'h00};
                    end
                    if (r_fidx == 4'd1) begin
                        n_rtype = {r_rtype[15:8], b};
                    end
                    if (r_fidx == 4'd8) begin
                        n_rdlen = {b, 8'h00};
                    end
                    if (r_fidx == 4'd9) begin
                        n_rdlen = {r_rdlen[15:8], b};
                    end
                    n_fidx = r_fidx + 4'd1;
                    if (n_fidx >= AFIX_BYTES) begin
                        n_fidx = '0;
                        n_addr = '0;
                        if (n_rdlen == 16'd0) begin
                            rec_done = 1'b1;
                        end else begin
                            n_phase = PH_ADAT;
                        end
                    end
                end
                PH_ADAT: begin
                    n_addr = {r_addr[23:0], b};
                    if (r_fidx < FIDX_MAX) begin
                        n_fidx = r_fidx + 4'd1;
                    end
                    n_rdlen = r_rdlen - 16'd1;
                    if (n_rdlen == 16'd0) begin
                        if (n_fidx == IPV4_BYTES && r_rtype == r_wanted) begin
                            hit     = 1'b1;
                            n_found = 1'b1;
                        end
                        rec_done = 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (rec_done) begin
                n_left  = r_left - 16'd1;
                n_phase = (n_left == 16'd0) ? PH_IDLE : PH_ALEN;
            end
        end

        if (n_offset < OFS_W'(HDR_BYTES)) begin
            status = ST_SHORT;
        end else if (n_rcode == RCODE_NXDOMAIN) begin
            status = ST_NXDOMAIN;
        end else if (n_rcode != 4'd0) begin
            status = ST_DNS_ERROR;
        end else if (n_ancount == 16'd0) begin
            status = ST_NO_RECS;
        end else if (n_phase == PH_QLEN || n_phase == PH_QLAB || n_phase == PH_QPTR
                     || n_phase == PH_QFIX || n_phase == PH_QBAD) begin
            status = ST_BAD_QUEST;
        end else if (n_found) begin
            status = ST_OK;
        end else begin
            status = ST_NO_A;
        end

        o_push.a.kind   = hit ? KIND_ADDR : KIND_STATUS;
        o_push.a.addr   = hit ? n_addr : 32'd0;
        o_push.a.status = hit ? ST_OK : status;
        o_push.a.last   = hit ? !r_in_last : 1'b1;
        o_push.b.kind   = KIND_STATUS;
        o_push.b.addr   = 32'd0;
        o_push.b.status = status;
        o_push.b.last   = 1'b1;
        o_push.vld_a    = r_in_vld && (hit || r_in_last);
        o_push.vld_b    = r_in_vld && hit && r_in_last;

        if (r_in_last) begin
            n_offset  = '0;
            n_phase   = PH_HDR;
            n_ancount = '0;
            n_rcode   = '0;
            n_left    = '0;
            n_fidx    = '0;
            n_lbl     = '0;
            n_rtype   = '0;
            n_rdlen   = '0;
            n_addr    = '0;
            n_found   = 1'b0;
        end
    end

endmodule

[src/drae_fifo.sv]
// ----------------------------------------------------------------------------
// drae_fifo
// Result queue: takes up to two results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
module drae_fifo
    import drae_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_vld,
    input  logic    i_rdy,
    output t_result o_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_result            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               pop;
    logic [CNT_W-1:0]   n_push;

    assign pop    = o_vld && i_rdy;
    assign o_vld  = r_cnt != '0;
    assign o_data = r_mem[r_rp];
    assign o_room = r_cnt <= CNT_W'(FIFO_DEPTH - 4);

    always_comb begin
        n_push = CNT_W'(i_push.vld_a) + CNT_W'(i_push.vld_b);
        n_wp   = r_wp + PTR_W'(n_push);
        n_rp   = pop ? r_rp + PTR_W'(1) : r_rp;
        n_cnt  = r_cnt + n_push - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld_a) begin
            r_mem[r_wp] <= i_push.a;
        end
        if (i_push.vld_b) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.b;
        end
    end

endmodule

[src/dns_reply_a_record_extractor_unit.sv]
// ----------------------------------------------------------------------------
// dns_reply_a_record_extractor_unit
// Streams a DNS reply byte by byte and reports A-record addresses and status.
// ----------------------------------------------------------------------------
// Accepts one message byte per cycle. A byte is parsed in the cycle after its
// transfer and its results (an address, the final status, or both on the
// last byte) enter an eight-entry result queue. s_tready stays high while the
// queue holds four results or fewer; with the output side taking a result
// every cycle the input never stalls. wanted_type resets to 1 (A record) and
// is written via i_cfg_we / i_cfg_wdata; the user must write it only while
// no message is in progress, as the block itself does not enforce this.
module dns_reply_a_record_extractor_unit
    import drae_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] ipv4_address, [34:32] status
    output logic        o_m_tuser,   // result_kind
    output logic        o_m_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_push   push;
    t_result head;
    logic    room;

    assign o_s_tready = room;

    drae_parser #(
        .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_s_tvalid && room),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_push      (push)
    );

    drae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_vld   (o_m_tvalid),
        .i_rdy   (i_m_tready),
        .o_data  (head)
    );

    assign o_m_tdata = {5'd0, head.status, head.addr};
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

[src/drae_checker.sv]
// ----------------------------------------------------------------------------
// drae_checker
// Port-level checks for the DNS reply A-record extractor.
// ----------------------------------------------------------------------------
module drae_checker
    import drae_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown right after reset");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_STATUS |->
            o_m_tlast && o_m_tdata[31:0] == 32'd0 && o_m_tdata[34:32] != 3'd7)
        else $error("malformed status result");

    a_addr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == KIND_ADDR |-> o_m_tdata[39:32] == 8'd0)
        else $error("address result carries status bits");

endmodule

bind dns_reply_a_record_extractor_unit drae_checker u_drae_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[tb/sv/dns_reply_a_record_extractor_unit_tb.sv]
// ----------------------------------------------------------------------------
// dns_reply_a_record_extractor_unit_tb
// Self-checking bench for the DNS reply A-record extractor. DNS replies are
// streamed in byte by byte: a few fixed messages first, then generated ones.
// Most generated replies are well formed with random content. The rest carry
// error codes, bad labels, cut-off records, trailing bytes, oversize bodies
// or are plain noise. A cycle-free parser model predicts every address and
// status item, and the output stream is compared field by field. The wanted
// record type is changed between message groups. Both stream sides idle in
// random bursts, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module dns_reply_a_record_extractor_unit_tb;
    import drae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int BYTES_PER_GROUP = 50;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // message bytes waiting to be sent: {end_of_message, data_byte}
    logic [8:0]  msg_bytes_q[$];
    logic [7:0]  msg_buf[$];
    t_result     reply_items_q[$];

    int          n_errors = 0;
    int          n_bytes_in = 0;
    int          s_idle_ratio = 0;
    int          m_idle_ratio = 0;
    int          s_gap = 0;
    int          m_gap = 0;
    int          m_hold = 0;
    bit          m_hold_done = 1'b0;
    int          quiet_cycles = 0;

    // parser model state
    logic [15:0] want_type = WANTED_DEF;
    logic [10:0] p_ofs;
    t_phase      p_phase;
    logic [15:0] p_an_count;
    logic [3:0]  p_rcode;
    logic [15:0] p_ans_left;
    logic [3:0]  p_fidx;
    logic [5:0]  p_lab_left;
    logic [15:0] p_rtype;
    logic [15:0] p_rd_left;
    logic [31:0] p_addr;
    logic        p_found;

    dns_reply_a_record_extractor_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic clear_parser();
        p_ofs = '0;
        p_phase = PH_HDR;
        p_an_count = '0;
        p_rcode = '0;
        p_ans_left = '0;
        p_fidx = '0;
        p_lab_left = '0;
        p_rtype = '0;
        p_rd_left = '0;
        p_addr = '0;
        p_found = 1'b0;
    endtask

    function automatic t_phase name_step(input logic [7:0] b, input t_phase ph_end,
                                         input t_phase ph_lab, input t_phase ph_ptr,
                                         input t_phase ph_bad);
        if (b == 8'h00)
            return ph_end;
        if (b[7:6] == 2'b11)
            return ph_ptr;
        if (b > {2'b00, LABEL_MAX})
            return ph_bad;
        p_lab_left = b[5:0];
        return ph_lab;
    endfunction

    task automatic finish_record();
        p_ans_left = p_ans_left - 16'd1;
        p_phase = (p_ans_left == 16'd0) ? PH_IDLE : PH_ALEN;
    endtask

    function automatic t_status reply_status();
        if (p_ofs < 11'(HDR_BYTES))
            return ST_SHORT;
        if (p_rcode == RCODE_NXDOMAIN)
            return ST_NXDOMAIN;
        if (p_rcode != 4'd0)
            return ST_DNS_ERROR;
        if (p_an_count == 16'd0)
            return ST_NO_RECS;
        if (p_phase >= PH_QLEN && p_phase <= PH_QBAD)
            return ST_BAD_QUEST;
        return p_found ? ST_OK : ST_NO_A;
    endfunction

    task automatic parse_reply_byte(input logic [7:0] b, input logic eom);
        bit      hit;
        t_result r;
        hit = 1'b0;
        if (p_ofs < 11'(MAX_MSG_BYTES_DEF)) begin
            case (p_phase)
                PH_HDR: begin
                    if (p_ofs == 11'(OFS_RCODE))
                        p_rcode = b[3:0];
                    if (p_ofs == 11'(OFS_ANCOUNT_HI))
                        p_an_count = {b, 8'h00};
                    if (p_ofs == 11'(OFS_ANCOUNT_LO))
                        p_an_count[7:0] = b;
                    if (p_ofs == 11'(OFS_HDR_END)) begin
                        if (p_rcode != 4'd0 || p_an_count == 16'd0) begin
                            p_phase = PH_IDLE;
                        end else begin
                            p_ans_left = p_an_count;
                            p_phase = PH_QLEN;
                        end
                    end
                end
                PH_QLEN: begin
                    p_phase = name_step(b, PH_QFIX, PH_QLAB, PH_QPTR, PH_QBAD);
                    p_fidx = '0;
                end
                PH_QLAB, PH_ALAB: begin
                    p_lab_left = p_lab_left - 6'd1;
                    if (p_lab_left == 6'd0)
                        p_phase = (p_phase == PH_QLAB) ? PH_QLEN : PH_ALEN;
                end
                PH_QPTR: begin
                    p_phase = PH_QFIX;
                    p_fidx = '0;
                end
                PH_QFIX: begin
                    p_fidx = p_fidx + 4'd1;
                    if (p_fidx >= QFIX_BYTES)
                        p_phase = PH_ALEN;
                end
                PH_ALEN: begin
                    p_phase = name_step(b, PH_AFIX, PH_ALAB, PH_APTR, PH_IDLE);
                    p_fidx = '0;
                end
                PH_APTR: begin
                    p_phase = PH_AFIX;
                    p_fidx = '0;
                end
                PH_AFIX: begin
                    if (p_fidx == 4'd0)
                        p_rtype = {b, 8'h00};
                    if (p_fidx == 4'd1)
                        p_rtype[7:0] = b;
                    if (p_fidx == 4'd8)
                        p_rd_left = {b, 8'h00};
                    if (p_fidx == 4'd9)
                        p_rd_left[7:0] = b;
                    p_fidx = p_fidx + 4'd1;
                    if (p_fidx >= AFIX_BYTES) begin
                        p_fidx = '0;
                        p_addr = '0;
                        if (p_rd_left == 16'd0)
                            finish_record();
                        else
                            p_phase = PH_ADAT;
                    end
                end
                PH_ADAT: begin
                    p_addr = {p_addr[23:0], b};
                    if (p_fidx < FIDX_MAX)
                        p_fidx = p_fidx + 4'd1;
                    p_rd_left = p_rd_left - 16'd1;
                    if (p_rd_left == 16'd0) begin
                        if (p_fidx == IPV4_BYTES && p_rtype == want_type) begin
                            hit = 1'b1;
                            p_found = 1'b1;
                        end
                        finish_record();
                    end
                end
                default: ;
            endcase
            p_ofs = p_ofs + 11'd1;
        end
        if (hit) begin
            r.kind = KIND_ADDR;
            r.addr = p_addr;
            r.status = ST_OK;
            r.last = !eom;
            reply_items_q.push_back(r);
        end
        if (eom) begin
            r.kind = KIND_STATUS;
            r.addr = '0;
            r.status = reply_status();
            r.last = 1'b1;
            reply_items_q.push_back(r);
            clear_parser();
        end
    endtask

    always @(posedge clk) begin : drv_p
        logic [8:0] nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                parse_reply_byte(s_tdata, s_tlast);
                n_bytes_in = n_bytes_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_tvalid <= 1'b0;
                    s_gap = s_gap - 1;
                end else if (msg_bytes_q.size() > 0) begin
                    nxt = msg_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt[7:0];
                    s_tlast <= nxt[8];
                    if (s_idle_ratio > 0 && $urandom_range(0, s_idle_ratio) == 0)
                        s_gap = $urandom_range(1, 16);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : mon_p
        t_result want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (reply_items_q.size() == 0) begin
                    $error("result transfer with nothing expected: kind %0d addr %h status %0d",
                           m_tuser, m_tdata[31:0], m_tdata[34:32]);
                    n_errors++;
                end else begin
                    want = reply_items_q.pop_front();
                    if (m_tuser !== want.kind) begin
                        $error("result_kind: expected %0d, got %0d", want.kind, m_tuser);
                        n_errors++;
                    end
                    if (m_tdata[31:0] !== want.addr) begin
                        $error("ipv4_address: expected %h, got %h", want.addr, m_tdata[31:0]);
                        n_errors++;
                    end
                    if (m_tdata[34:32] !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tdata[34:32]);
                        n_errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0d, got %0d", want.last, m_tlast);
                        n_errors++;
                    end
                end
            end
            if (m_hold > 0) begin
                m_tready <= 1'b0;
                m_hold = m_hold - 1;
            end else if (!m_hold_done && n_bytes_in >= 150) begin
                m_tready <= 1'b0;
                m_hold = 600;
                m_hold_done = 1'b1;
            end else if (m_gap > 0) begin
                m_tready <= 1'b0;
                m_gap = m_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_idle_ratio > 0 && $urandom_range(0, m_idle_ratio) == 0)
                    m_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic queue_msg();
        for (int i = 0; i < msg_buf.size(); i++)
            msg_bytes_q.push_back({(i == msg_buf.size() - 1) ? 1'b1 : 1'b0, msg_buf[i]});
    endtask

    task automatic add_name(input bit allow_bad, output bit broken);
        int nlab;
        int len;
        broken = 1'b0;
        nlab = $urandom_range(0, 3);
        for (int k = 0; k < nlab; k++) begin
            len = ($urandom_range(0, 19) == 0) ? 63 : $urandom_range(1, 8);
            msg_buf.push_back(8'(len));
            repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (allow_bad && $urandom_range(0, 24) == 0) begin
            msg_buf.push_back(8'($urandom_range(64, 191)));
            repeat ($urandom_range(0, 5)) msg_buf.push_back(8'($urandom_range(0, 255)));
            broken = 1'b1;
        end else if ($urandom_range(0, 1) == 0) begin
            msg_buf.push_back(8'hC0 | 8'($urandom_range(0, 63)));
            msg_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            msg_buf.push_back(8'h00);
        end
    endtask

    task automatic build_reply(input bit oversize);
        int          n_an;
        int          n_rec;
        int          cut;
        logic [15:0] rtype;
        logic [15:0] rdlen;
        bit          broken;
        msg_buf.delete();
        broken = 1'b0;
        if (!oversize && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) msg_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat (12) msg_buf.push_back(8'($urandom_range(0, 255)));
            if (oversize || $urandom_range(0, 5) != 0)
                msg_buf[3] = msg_buf[3] & 8'hF0;
            case ($urandom_range(0, 9))
                0: n_an = 0;
                1: n_an = $urandom_range(4, 8);
                default: n_an = $urandom_range(1, 3);
            endcase
            if (oversize)
                n_an = 64;
            msg_buf[6] = n_an[15:8];
            msg_buf[7] = n_an[7:0];
            n_rec = n_an;
            if (!oversize && $urandom_range(0, 19) == 0)
                msg_buf[6] = 8'($urandom_range(1, 255));
            else if (n_an > 0 && $urandom_range(0, 7) == 0)
                n_rec = n_an - 1;
            add_name(!oversize, broken);
            if (!broken)
                repeat (4) msg_buf.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < n_rec && !broken; i++) begin
                if ($urandom_range(0, 4) < 3 || oversize) begin
                    msg_buf.push_back(8'hC0 | 8'($urandom_range(0, 63)));
                    msg_buf.push_back(8'($urandom_range(0, 255)));
                end else begin
                    add_name(1'b1, broken);
                end
                if (!broken) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: rtype = 16'd1;
                        3, 4:    rtype = 16'($urandom_range(0, 65535));
                        default: rtype = want_type;
                    endcase
                    if (oversize)
                        rtype = want_type;
                    case ($urandom_range(0, 29))
                        0:                rdlen = 16'd20;
                        1, 2, 3, 4, 5, 6: rdlen = 16'($urandom_range(0, 7));
                        default:          rdlen = 16'd4;
                    endcase
                    if (oversize)
                        rdlen = 16'd4;
                    msg_buf.push_back(rtype[15:8]);
                    msg_buf.push_back(rtype[7:0]);
                    repeat (6) msg_buf.push_back(8'($urandom_range(0, 255)));
                    msg_buf.push_back(rdlen[15:8]);
                    msg_buf.push_back(rdlen[7:0]);
                    repeat (rdlen) msg_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            if (!oversize && $urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 6)) msg_buf.push_back(8'($urandom_range(0, 255)));
            if (!oversize && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, msg_buf.size());
                while (msg_buf.size() > cut)
                    void'(msg_buf.pop_back());
            end
        end
        queue_msg();
    endtask

    task automatic wait_drained();
        while (msg_bytes_q.size() != 0 || s_tvalid || reply_items_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_wanted(input logic [15:0] v);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        want_type = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stim_p
        logic [15:0] settings[6];
        int          start_cnt;
        settings = '{16'd1, 16'h0000, 16'hFFFF, 16'd28, 16'd0, 16'd1};
        settings[4] = 16'($urandom_range(2, 65534));
        clear_parser();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        msg_buf = '{8'hFF};
        queue_msg();
        msg_buf = '{8'h00};
        queue_msg();
        msg_buf = '{8'h12, 8'h34, 8'h81, 8'h80, 8'h00, 8'h01, 8'h00, 8'h01,
                    8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h01, 8'h00, 8'h01,
                    8'hC0, 8'h0C, 8'h00, 8'h01, 8'h00, 8'h01,
                    8'h00, 8'h00, 8'h0E, 8'h10, 8'h00, 8'h04,
                    8'hC0, 8'hA8, 8'h01, 8'hFE};
        queue_msg();

        for (int g = 0; g < 6; g++) begin
            if (g > 0)
                write_wanted(settings[g]);
            s_idle_ratio = (g == 2 || g == 5) ? 0 : $urandom_range(2, 10);
            m_idle_ratio = (g == 2 || g == 5) ? 0 : $urandom_range(2, 10);
            start_cnt = n_bytes_in + msg_bytes_q.size();
            if (g == 1)
                build_reply(1'b1);
            while (n_bytes_in + msg_bytes_q.size() - start_cnt < BYTES_PER_GROUP)
                build_reply(1'b0);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
